// ----- hw/rtl/dhkt_pkg.sv -----
// Shared types and constants of the double-hash keyed table.
package dhkt_pkg;

  localparam int unsigned KeyW     = 31;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CountW   = 7;
  localparam int unsigned KeyCntW  = $clog2(KeyW);
  localparam int unsigned StepBias = 8;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeFind   = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_e;

endpackage

// ----- hw/rtl/double_hash_keyed_table.sv -----
// Keyed record table with open addressing and double hashing.
// Flow: hash unit, then 1 to TABLE_SLOTS slot probes, then the result and output registers.
// Items: one at a time, with one slot-memory read per probe; a stalled result holds
//   the next item back.
// Reset: asynchronous, clears control and the record count, then sweeps every slot of
//   the valid memory before the first transfer is taken.
module double_hash_keyed_table #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [dhkt_pkg::KeyW-1:0]        record_key_i,
  input  logic signed [dhkt_pkg::ValW-1:0] record_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic signed [dhkt_pkg::ValW-1:0] value_out_o,
  output dhkt_pkg::status_e                status_o,
  output logic [dhkt_pkg::CountW-1:0]      stored_count_o
);
  import dhkt_pkg::*;

  localparam int unsigned SW  = $clog2(TABLE_SLOTS);
  localparam int unsigned IW  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned KVW = KeyW + ValW;
  localparam logic [IW-1:0] ProbeMax  = IW'(TABLE_SLOTS);
  localparam logic [IW-1:0] ProbeLast = IW'(TABLE_SLOTS - 1);
  localparam logic [SW:0]   NVal      = (SW+1)'(TABLE_SLOTS);
  localparam logic [SW-1:0] SlotLast  = SW'(TABLE_SLOTS - 1);

  state_e state_q, state_d;

  // Latched item
  logic            mode_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;

  // Hash unit
  logic          hash_start, hash_done;
  logic [SW-1:0] hash_home, hash_step;

  // Probe walk
  logic [SW-1:0] pos_q, step_q, rd_pos_q, clr_q;
  logic [IW-1:0] iss_q, evl_q;
  logic          pend_q;
  logic [SW:0]   pos_sum;
  logic [SW-1:0] pos_nx;

  // Slot memories: valid bits (swept at reset) and key/value words (never cleared)
  logic            valid_mem [TABLE_SLOTS];
  logic [KVW-1:0]  kv_mem    [TABLE_SLOTS];
  logic            vrd_q;
  logic [KVW-1:0]  kvrd_q;
  logic            rd_en, v_we, v_wd, kv_we;
  logic [SW-1:0]   v_wa;

  // Evaluation of the slot just read
  logic slot_empty, slot_match, probe_last, probe_stop;

  // Result, record count, output register
  logic [IW-1:0]   count_q;
  logic            res_hit_q;
  logic [ValW-1:0] res_val_q;
  status_e         res_status_q;
  logic            out_valid_q, out_free;
  logic [IW+CountW-1:0] count_ext;

  dhkt_hash #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (record_key_i),
    .done_o (hash_done),
    .home_o (hash_home),
    .step_o (hash_step)
  );

  // Next probe slot: step is below the slot count, so one subtract wraps it.
  always_comb begin
    pos_sum = {1'b0, pos_q} + {1'b0, step_q};
    pos_nx  = (pos_sum >= NVal) ? SW'(pos_sum - NVal) : pos_sum[SW-1:0];
  end

  always_comb begin
    slot_empty = !vrd_q;
    slot_match = vrd_q && (kvrd_q[KVW-1:ValW] == key_q);
    probe_last = (evl_q == ProbeLast);
    probe_stop = pend_q && (slot_empty || slot_match || probe_last);
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == SlotLast) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_HASH;
      S_HASH:  if (hash_done) state_d = S_PROBE;
      S_PROBE: if (probe_stop) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    hash_start = (state_q == S_IDLE) && in_valid_i;
    rd_en      = (state_q == S_PROBE) && (iss_q != ProbeMax);
    v_we       = 1'b0;
    v_wa       = rd_pos_q;
    v_wd       = 1'b1;
    kv_we      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        v_we = 1'b1;
        v_wa = clr_q;
        v_wd = 1'b0;
      end
      S_PROBE: begin
        kv_we = probe_stop && (mode_q == ModeInsert) && (slot_empty || slot_match);
        v_we  = probe_stop && (mode_q == ModeInsert) && slot_empty;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) valid_mem[v_wa] <= v_wd;
    if (rd_en) vrd_q <= valid_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) kv_mem[rd_pos_q] <= {key_q, val_q};
    if (rd_en) kvrd_q <= kv_mem[pos_q];
  end

  // Control registers: sweep index, probe counters, record count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      iss_q       <= '0;
      evl_q       <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_HASH) begin
        iss_q  <= '0;
        evl_q  <= '0;
        pend_q <= 1'b0;
      end else if (state_q == S_PROBE) begin
        pend_q <= rd_en && !probe_stop;
        if (rd_en) iss_q <= iss_q + 1'b1;
        if (pend_q) evl_q <= evl_q + 1'b1;
      end
      if (v_we && v_wd) count_q <= count_q + 1'b1;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: item, walk position, result, output fields
  always_ff @(posedge clk_i) begin
    if (hash_start) begin
      mode_q <= mode_i;
      key_q  <= record_key_i;
      val_q  <= record_value_i;
    end
    if (state_q == S_HASH && hash_done) begin
      pos_q  <= hash_home;
      step_q <= hash_step;
    end else if (rd_en) begin
      pos_q <= pos_nx;
    end
    if (rd_en) rd_pos_q <= pos_q;
    if (probe_stop && state_q == S_PROBE) begin
      res_hit_q <= slot_match;
      if (mode_q == ModeInsert) begin
        res_val_q <= '0;
        if (slot_empty)      res_status_q <= ST_INSERTED;
        else if (slot_match) res_status_q <= ST_UPDATED;
        else                 res_status_q <= ST_FULL;
      end else begin
        if (slot_match) begin
          res_status_q <= ST_FOUND;
          res_val_q    <= kvrd_q[ValW-1:0];
        end else begin
          res_status_q <= ST_NOT_FOUND;
          res_val_q    <= '0;
        end
      end
    end
    if (state_q == S_DONE && out_free) begin
      hit_o          <= res_hit_q;
      value_out_o    <= res_val_q;
      status_o       <= res_status_q;
      stored_count_o <= count_ext[CountW-1:0];
    end
  end

  assign count_ext   = {{CountW{1'b0}}, count_q};
  assign out_valid_o = out_valid_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ProbeMax)
    else $error("record count above slot count");

  a_eval_behind_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> evl_q <= iss_q)
    else $error("probe evaluated before it was read");

  a_write_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kv_we |-> state_q == S_PROBE && pend_q)
    else $error("slot write outside a probe decision");

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == ST_UPDATED || status_o == ST_FOUND)
    else $error("hit with a miss status");

endmodule

// ----- hw/rtl/dhkt_hash.sv -----
// Home slot and probe step of a key, by reciprocal multiplication; quotients, then remainders, are registered.
module dhkt_hash #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [dhkt_pkg::KeyW-1:0]             key_i,
  output logic                                  done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]        home_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]        step_o
);
  import dhkt_pkg::*;

  localparam int unsigned SW    = $clog2(TABLE_SLOTS);
  localparam int unsigned Half  = TABLE_SLOTS / 2;
  localparam int unsigned HW    = $clog2(Half);
  localparam int unsigned Bias  = StepBias % Half;
  localparam int unsigned MW    = KeyW + 1;
  localparam int unsigned PW    = KeyW + MW;
  localparam logic [SW:0] HVal  = (SW+1)'(Half);
  localparam logic [SW:0] BVal  = (SW+1)'(Bias);
  localparam logic [SW:0] One   = (SW+1)'(1);
  // Rounded-up reciprocals: (key * R) >> (KeyW + clog2(d)) equals key / d for every key.
  localparam logic [MW-1:0] NRecip =
      MW'(((64'd1 << (KeyW + SW)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
  localparam logic [MW-1:0] HRecip =
      MW'(((64'd1 << (KeyW + HW)) + 64'(Half) - 64'd1) / 64'(Half));

  logic            s1_q, s2_q, done_q;
  logic [KeyW-1:0] key_q;
  logic [KeyW-1:0] qn_q, qh_q;
  logic [SW-1:0]   rn_q, rh_q;
  logic [PW-1:0]   prod_n, prod_h;
  logic [KeyW-1:0] rem_n, rem_h;
  logic [SW:0]     diff, step_w;

  // Quotients by the slot count and by half of it.
  always_comb begin
    prod_n = PW'(key_q) * PW'(NRecip);
    prod_h = PW'(key_q) * PW'(HRecip);
  end

  // Remainders: key minus quotient times divisor.
  always_comb begin
    rem_n = key_q - qn_q * KeyW'(TABLE_SLOTS);
    rem_h = key_q - qh_q * KeyW'(Half);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) key_q <= key_i;
    if (s1_q) begin
      qn_q <= KeyW'(prod_n >> (KeyW + SW));
      qh_q <= KeyW'(prod_h >> (KeyW + HW));
    end
    if (s2_q) begin
      rn_q <= rem_n[SW-1:0];
      rh_q <= rem_h[SW-1:0];
    end
  end

  // Floored (key - 8) mod half, from key mod half; zero becomes one.
  always_comb begin
    diff   = ({1'b0, rh_q} >= BVal) ? {1'b0, rh_q} - BVal : {1'b0, rh_q} + HVal - BVal;
    step_w = (diff == '0) ? One : diff;
  end

  assign done_o = done_q;
  assign home_o = rn_q;
  assign step_o = step_w[SW-1:0];

endmodule
